/* design/pli_pkg.sv */
// Shared types, codes and sizing helpers for the piecewise-linear interpolator.
`timescale 1ns / 1ps

package pli_pkg;

  localparam int CountWidth  = 5;
  localparam int IndexWidth  = 4;
  localparam int StatusWidth = 2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_QUERY   = 2'd1,
    KIND_TOO_FEW = 2'd2
  } kind_e;

  typedef enum logic [StatusWidth-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_FEW   = 2'd1,
    STATUS_ZERO_SPAN = 2'd2
  } status_e;

  function automatic int entry_width(input int depth, input int sw);
    return $bits(kind_e) + $clog2(depth) + $clog2(depth + 1) + 2 * sw;
  endfunction

endpackage

/* design/piecewise_linear_interpolator.sv */
// Top level of the piecewise-linear interpolator: front, queue and back part.
// Write beats store one (input, output) breakpoint and give no result; query beats give one
// result beat with the interpolated Q8.8 value, a status and a saturation flag. A two-entry
// queue sits between the front, which accepts and classifies beats, and the back, which runs
// them one at a time. In the back a query with too few points goes straight to its result; a
// full query runs a linear search over the breakpoints, reading each through the registered
// table read, and then the bit-serial restoring divider. The point count is written through
// the configuration channel, which is always ready; it must be written only while the block is
// idle, and the block itself does not enforce this.
`timescale 1ns / 1ps

module piecewise_linear_interpolator import pli_pkg::*; #(
  parameter int TABLE_DEPTH  = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [CountWidth-1:0]          cfg_point_count_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           operation_i,
  input  logic [IndexWidth-1:0]          point_index_i,
  input  logic signed [SAMPLE_WIDTH-1:0] point_input_i,
  input  logic signed [SAMPLE_WIDTH-1:0] point_output_i,
  input  logic signed [SAMPLE_WIDTH-1:0] query_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] result_value_o,
  output logic [StatusWidth-1:0]         status_o,
  output logic                           saturated_o
);

  localparam int EntryWidth = entry_width(TABLE_DEPTH, SAMPLE_WIDTH);
  localparam int QueueDepth = 2;

  logic                  q_push;
  logic [EntryWidth-1:0] q_wdata;
  logic                  q_full;
  logic                  q_pop;
  logic [EntryWidth-1:0] q_rdata;
  logic                  q_empty;

  pli_front #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_point_count_i (cfg_point_count_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .point_index_i     (point_index_i),
    .point_input_i     (point_input_i),
    .point_output_i    (point_output_i),
    .query_value_i     (query_value_i),
    .q_push_o          (q_push),
    .q_entry_o         (q_wdata),
    .q_full_i          (q_full)
  );

  pli_queue #(
    .WIDTH (EntryWidth),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  pli_engine #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_entry_i      (q_rdata),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .saturated_o    (saturated_o)
  );

endmodule

/* design/pli_queue.sv */
// Small first-in first-out queue between the front and back parts.
`timescale 1ns / 1ps

module pli_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_q [DEPTH];
  logic [PtrW-1:0]  wptr_q;
  logic [PtrW-1:0]  rptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = slots_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= next_ptr(wptr_q);
      end
      if (do_pop) begin
        rptr_q <= next_ptr(rptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wptr_q] <= data_i;
    end
  end

endmodule

/* design/pli_front.sv */
// Front part: holds the point count, accepts input beats and classifies them.
`timescale 1ns / 1ps

module pli_front import pli_pkg::*; #(
  parameter int TABLE_DEPTH  = 16,
  parameter int SAMPLE_WIDTH = 16,
  localparam int EntryWidth  = entry_width(TABLE_DEPTH, SAMPLE_WIDTH)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [CountWidth-1:0]          cfg_point_count_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           operation_i,
  input  logic [IndexWidth-1:0]          point_index_i,
  input  logic signed [SAMPLE_WIDTH-1:0] point_input_i,
  input  logic signed [SAMPLE_WIDTH-1:0] point_output_i,
  input  logic signed [SAMPLE_WIDTH-1:0] query_value_i,
  output logic                           q_push_o,
  output logic [EntryWidth-1:0]          q_entry_o,
  input  logic                           q_full_i
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int SW = SAMPLE_WIDTH;

  typedef struct packed {
    kind_e           kind;
    logic [AW-1:0]   slot;
    logic [CW-1:0]   count;
    logic [SW-1:0]   data_a;
    logic [SW-1:0]   data_b;
  } entry_t;

  logic [CountWidth-1:0] point_count_q;
  logic [CW-1:0]         eff_count;
  logic                  slot_ok;
  entry_t                entry;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= '0;
    end else if (cfg_valid_i) begin
      point_count_q <= cfg_point_count_i;
    end
  end

  assign eff_count = (32'(point_count_q) > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                        : CW'(point_count_q);
  assign slot_ok   = (32'(point_index_i) < TABLE_DEPTH);

  always_comb begin
    entry.slot  = AW'(point_index_i);
    entry.count = eff_count;
    if (operation_i == OP_WRITE) begin
      entry.kind   = KIND_WRITE;
      entry.data_a = point_input_i;
      entry.data_b = point_output_i;
    end else begin
      entry.kind   = (eff_count < CW'(2)) ? KIND_TOO_FEW : KIND_QUERY;
      entry.data_a = query_value_i;
      entry.data_b = '0;
    end
  end

  // Writes to slots beyond the table are accepted and dropped here.
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && ((operation_i == OP_QUERY) || slot_ok);
  assign q_entry_o  = EntryWidth'(entry);

endmodule

/* design/pli_engine.sv */
// Back part: breakpoint memory, segment search, divider and result register.
`timescale 1ns / 1ps

module pli_engine import pli_pkg::*; #(
  parameter int TABLE_DEPTH  = 16,
  parameter int SAMPLE_WIDTH = 16,
  localparam int EntryWidth  = entry_width(TABLE_DEPTH, SAMPLE_WIDTH)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  input  logic [EntryWidth-1:0]          q_entry_i,
  output logic                           q_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] result_value_o,
  output logic [StatusWidth-1:0]         status_o,
  output logic                           saturated_o
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int SW  = SAMPLE_WIDTH;
  localparam int PW  = 2 * SW + 2;
  localparam int RW  = SW + 2;
  localparam int DCW = $clog2(PW + 1);
  localparam int XW  = SW + 3;
  localparam logic signed [XW-1:0] SMax = XW'((longint'(1) <<< (SW - 1)) - 1);
  localparam logic signed [XW-1:0] SMin = -SMax - XW'(1);

  typedef struct packed {
    kind_e           kind;
    logic [AW-1:0]   slot;
    logic [CW-1:0]   count;
    logic [SW-1:0]   data_a;
    logic [SW-1:0]   data_b;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_RD_A,
    S_RD_B,
    S_DIFF,
    S_MUL,
    S_DIV,
    S_SUM,
    S_EMIT
  } state_e;

  entry_t                 entry;
  state_e                 state_q;
  logic [2*SW-1:0]        mem [TABLE_DEPTH];
  logic [2*SW-1:0]        rdata_q;
  logic [AW-1:0]          raddr;
  logic                   mem_we;
  logic [AW-1:0]          idx_q;
  logic [AW-1:0]          a_q;
  logic [AW-1:0]          b_q;
  logic [CW-1:0]          n_q;
  logic signed [SW-1:0]   query_q;
  logic signed [SW-1:0]   in1_q;
  logic signed [SW-1:0]   out1_q;
  logic [SW:0]            din_mag_q;
  logic [SW:0]            dout_mag_q;
  logic [SW:0]            dq_mag_q;
  logic                   neg_q;
  logic [PW-1:0]          prod_q;
  logic [RW-1:0]          rem_q;
  logic [DCW-1:0]         cnt_q;
  logic signed [SW-1:0]   res_pend_q;
  status_e                status_pend_q;
  logic                   sat_pend_q;
  logic                   out_valid_q;
  logic signed [SW-1:0]   result_q;
  status_e                status_q;
  logic                   sat_q;

  logic signed [SW-1:0]   rd_in;
  logic signed [SW-1:0]   rd_out;
  logic                   less;
  logic signed [SW:0]     din;
  logic signed [SW:0]     dout;
  logic signed [SW:0]     dq;
  logic [SW:0]            din_mag;
  logic [SW:0]            dout_mag;
  logic [SW:0]            dq_mag;
  logic [RW-1:0]          rem_sh;
  logic                   geq;
  logic [RW-1:0]          rem_next;
  logic [SW:0]            mag_c;
  logic [XW-1:0]          mag_x;
  logic signed [XW-1:0]   sum;
  logic signed [SW-1:0]   res_sat;
  logic                   sum_sat;

  assign entry   = entry_t'(q_entry_i);
  assign q_pop_o = (state_q == S_IDLE) && !q_empty_i;
  assign mem_we  = q_pop_o && (entry.kind == KIND_WRITE);

  always_comb begin
    case (state_q)
      S_RD_A:  raddr = a_q;
      S_RD_B:  raddr = b_q;
      default: raddr = idx_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[entry.slot] <= {entry.data_a, entry.data_b};
    end
    rdata_q <= mem[raddr];
  end

  assign rd_in  = rdata_q[2*SW-1:SW];
  assign rd_out = rdata_q[SW-1:0];
  assign less   = (query_q < rd_in);

  assign din      = {rd_in[SW-1], rd_in} - {in1_q[SW-1], in1_q};
  assign dout     = {rd_out[SW-1], rd_out} - {out1_q[SW-1], out1_q};
  assign dq       = {query_q[SW-1], query_q} - {in1_q[SW-1], in1_q};
  assign din_mag  = din[SW]  ? (~din + (SW+1)'(1))  : din;
  assign dout_mag = dout[SW] ? (~dout + (SW+1)'(1)) : dout;
  assign dq_mag   = dq[SW]   ? (~dq + (SW+1)'(1))   : dq;

  // One restoring division step; the quotient shifts into the product register.
  assign rem_sh   = {rem_q[RW-2:0], prod_q[PW-1]};
  assign geq      = (rem_sh >= {1'b0, din_mag_q});
  assign rem_next = geq ? (rem_sh - {1'b0, din_mag_q}) : rem_sh;

  // Any magnitude at or above the clamp value saturates the sum either way.
  assign mag_c   = (|prod_q[PW-1:SW+1]) ? '1 : prod_q[SW:0];
  assign mag_x   = {2'b00, mag_c};
  assign sum     = {{3{out1_q[SW-1]}}, out1_q} + (neg_q ? (~mag_x + XW'(1)) : mag_x);
  assign sum_sat = (sum > SMax) || (sum < SMin);
  assign res_sat = (sum > SMax) ? SMax[SW-1:0] :
                   (sum < SMin) ? SMin[SW-1:0] : sum[SW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      idx_q         <= '0;
      a_q           <= '0;
      b_q           <= '0;
      n_q           <= '0;
      query_q       <= '0;
      in1_q         <= '0;
      out1_q        <= '0;
      din_mag_q     <= '0;
      dout_mag_q    <= '0;
      dq_mag_q      <= '0;
      neg_q         <= 1'b0;
      prod_q        <= '0;
      rem_q         <= '0;
      cnt_q         <= '0;
      res_pend_q    <= '0;
      status_pend_q <= STATUS_OK;
      sat_pend_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      result_q      <= '0;
      status_q      <= STATUS_OK;
      sat_q         <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            query_q <= entry.data_a;
            n_q     <= entry.count;
            idx_q   <= '0;
            unique case (entry.kind)
              KIND_QUERY: begin
                state_q <= S_SRCH_RD;
              end
              KIND_TOO_FEW: begin
                res_pend_q    <= '0;
                status_pend_q <= STATUS_TOO_FEW;
                sat_pend_q    <= 1'b0;
                state_q       <= S_EMIT;
              end
              default: begin
                state_q <= S_IDLE;
              end
            endcase
          end
        end
        S_SRCH_RD: begin
          state_q <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          if (less) begin
            a_q     <= (idx_q == '0) ? '0 : idx_q - AW'(1);
            b_q     <= (idx_q == '0) ? AW'(1) : idx_q;
            state_q <= S_RD_A;
          end else if (CW'(idx_q) == n_q - CW'(1)) begin
            a_q     <= AW'(n_q - CW'(2));
            b_q     <= AW'(n_q - CW'(1));
            state_q <= S_RD_A;
          end else begin
            idx_q   <= idx_q + AW'(1);
            state_q <= S_SRCH_RD;
          end
        end
        S_RD_A: begin
          state_q <= S_RD_B;
        end
        S_RD_B: begin
          in1_q   <= rd_in;
          out1_q  <= rd_out;
          state_q <= S_DIFF;
        end
        S_DIFF: begin
          if (din == '0) begin
            res_pend_q    <= '0;
            status_pend_q <= STATUS_ZERO_SPAN;
            sat_pend_q    <= 1'b0;
            state_q       <= S_EMIT;
          end else begin
            din_mag_q  <= din_mag;
            dout_mag_q <= dout_mag;
            dq_mag_q   <= dq_mag;
            neg_q      <= dout[SW] ^ dq[SW] ^ din[SW];
            state_q    <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= PW'(dout_mag_q) * PW'(dq_mag_q);
          rem_q   <= '0;
          cnt_q   <= DCW'(PW);
          state_q <= S_DIV;
        end
        S_DIV: begin
          prod_q <= {prod_q[PW-2:0], geq};
          rem_q  <= rem_next;
          cnt_q  <= cnt_q - DCW'(1);
          if (cnt_q == DCW'(1)) begin
            state_q <= S_SUM;
          end
        end
        S_SUM: begin
          res_pend_q    <= res_sat;
          status_pend_q <= STATUS_OK;
          sat_pend_q    <= sum_sat;
          state_q       <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            result_q    <= res_pend_q;
            status_q    <= status_pend_q;
            sat_q       <= sat_pend_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_q;
  assign status_o       = status_q;
  assign saturated_o    = sat_q;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the piecewise-linear interpolator with its own result predictor.
`timescale 1ns / 1ps

module tb;
  import pli_pkg::*;

  localparam int Depth       = 16;
  localparam int SampleWidth = 16;
  localparam int DrainCycles = 200;
  localparam int StuckLimit  = 10000;
  localparam int HoldCycles  = 400;
  localparam int PhaseItems  = 100;

  typedef logic signed [SampleWidth-1:0] sample_t;

  typedef struct packed {
    sample_t value;
    status_e status;
    logic    sat;
  } result_t;

  typedef struct packed {
    logic                  op;
    logic [IndexWidth-1:0] idx;
    sample_t               pin;
    sample_t               pout;
    sample_t               q;
  } beat_t;

  typedef enum logic {
    ROW_BEAT  = 1'b0,
    ROW_COUNT = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    beat_t                 beat;
    logic [CountWidth-1:0] count;
    logic                  typed;
    result_t               want;
  } row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CountWidth-1:0] cfg_point_count_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  operation_i;
  logic [IndexWidth-1:0] point_index_i;
  sample_t               point_input_i;
  sample_t               point_output_i;
  sample_t               query_value_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  sample_t               result_value_o;
  logic [StatusWidth-1:0] status_o;
  logic                  saturated_o;

  sample_t               bp_input  [Depth];
  sample_t               bp_output [Depth];
  logic [CountWidth-1:0] bp_count;
  result_t               pending_results [$];
  row_t                  directed_rows [$];
  int                    mismatches = 0;
  int                    quiet_cycles = 0;
  int                    tx_idle_pct = 0;
  int                    rx_stall_pct = 0;
  bit                    hold_go = 1'b0;
  logic                  rx_hold;

  piecewise_linear_interpolator #(
    .TABLE_DEPTH (Depth),
    .SAMPLE_WIDTH(SampleWidth)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_point_count_i(cfg_point_count_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .point_index_i    (point_index_i),
    .point_input_i    (point_input_i),
    .point_output_i   (point_output_i),
    .query_value_i    (query_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_value_o   (result_value_o),
    .status_o         (status_o),
    .saturated_o      (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic sample_t rand_sample();
    logic [31:0] r;
    r = $urandom;
    return r[SampleWidth-1:0];
  endfunction

  function automatic result_t interpolate(input sample_t q);
    int      n, i, lo_i, hi_i;
    bit      found;
    longint  in1, in2, out1, out2, qv, din, res;
    result_t r;
    r.value  = '0;
    r.status = STATUS_OK;
    r.sat    = 1'b0;
    n = (bp_count > Depth) ? Depth : bp_count;
    if (n < 2) begin
      r.status = STATUS_TOO_FEW;
    end else begin
      lo_i  = n - 2;
      hi_i  = n - 1;
      found = 1'b0;
      for (i = 0; i < n; i++) begin
        if (!found && q < bp_input[i]) begin
          found = 1'b1;
          lo_i  = (i == 0) ? 0 : i - 1;
          hi_i  = (i == 0) ? 1 : i;
        end
      end
      in1  = bp_input[lo_i];
      in2  = bp_input[hi_i];
      out1 = bp_output[lo_i];
      out2 = bp_output[hi_i];
      qv   = q;
      din  = in2 - in1;
      if (din == 0) begin
        r.status = STATUS_ZERO_SPAN;
      end else begin
        res = out1 + ((out2 - out1) * (qv - in1)) / din;
        if (res > 32767) begin
          res   = 32767;
          r.sat = 1'b1;
        end else if (res < -32768) begin
          res   = -32768;
          r.sat = 1'b1;
        end
        r.value = res[SampleWidth-1:0];
      end
    end
    return r;
  endfunction

  function automatic beat_t make_write(input logic [IndexWidth-1:0] idx, input sample_t pin,
                                       input sample_t pout);
    beat_t b;
    b.op   = OP_WRITE;
    b.idx  = idx;
    b.pin  = pin;
    b.pout = pout;
    b.q    = rand_sample();
    return b;
  endfunction

  function automatic beat_t make_query(input sample_t q);
    beat_t b;
    logic [31:0] r;
    r      = $urandom;
    b.op   = OP_QUERY;
    b.idx  = r[IndexWidth-1:0];
    b.pin  = rand_sample();
    b.pout = rand_sample();
    b.q    = q;
    return b;
  endfunction

  function automatic void dir_beat(input logic op, input int idx, input int pin, input int pout,
                                   input int q, input bit typed, input int val,
                                   input status_e st, input bit sat);
    row_t r;
    r.kind       = ROW_BEAT;
    r.beat.op    = op;
    r.beat.idx   = idx[IndexWidth-1:0];
    r.beat.pin   = pin[SampleWidth-1:0];
    r.beat.pout  = pout[SampleWidth-1:0];
    r.beat.q     = q[SampleWidth-1:0];
    r.count      = '0;
    r.typed      = typed;
    r.want.value = val[SampleWidth-1:0];
    r.want.status = st;
    r.want.sat   = sat;
    directed_rows.push_back(r);
  endfunction

  function automatic void dir_count(input int c);
    row_t r;
    r       = '0;
    r.kind  = ROW_COUNT;
    r.count = c[CountWidth-1:0];
    directed_rows.push_back(r);
  endfunction

  task automatic send_beat(input beat_t b, input bit typed, input result_t want);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= b.op;
    point_index_i  <= b.idx;
    point_input_i  <= b.pin;
    point_output_i <= b.pout;
    query_value_i  <= b.q;
    do @(posedge clk_i); while (in_stall_o);
    if (b.op == OP_QUERY) begin
      pending_results.push_back(typed ? want : interpolate(b.q));
    end else begin
      bp_input[b.idx]  = b.pin;
      bp_output[b.idx] = b.pout;
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic set_count(input logic [CountWidth-1:0] c);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid_i       <= 1'b1;
    cfg_point_count_i <= c;
    do @(posedge clk_i); while (!cfg_ready_o);
    bp_count = c;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_idling(input int tx, input int rx);
    tx_idle_pct = tx;
    rx_stall_pct <= rx;
  endtask

  // Loads all slots with ascending inputs; steps are sometimes zero to form zero-span segments.
  task automatic refill_table();
    int lo_v, step_max, v, k;
    bit smooth;
    lo_v     = $urandom_range(0, 32768) - 32768;
    step_max = (32767 - lo_v) / (Depth - 1);
    if ($urandom_range(0, 1) == 0) step_max = step_max / 64;
    if (step_max < 1) step_max = 1;
    smooth = $urandom_range(0, 1);
    v = lo_v;
    for (k = 0; k < Depth; k++) begin
      send_beat(make_write(k[IndexWidth-1:0], v[SampleWidth-1:0],
                           smooth ? sample_t'($urandom_range(0, 1023) - 512) : rand_sample()),
                1'b0, '0);
      if ($urandom_range(0, 19) != 0) v = v + $urandom_range(1, step_max);
    end
  endtask

  task automatic run_phase(input int count_val, input int n_items, input bit refill,
                           input bit pause_mid, input bit hold);
    int      k, sel, n, seg, lo_v, hi_v;
    sample_t q;
    logic [31:0] r;
    if (refill) refill_table();
    set_count(count_val[CountWidth-1:0]);
    if (hold) hold_go = 1'b1;
    n = (count_val > Depth) ? Depth : count_val;
    for (k = 0; k < n_items; k++) begin
      if (pause_mid && k == n_items / 2) wait_drained();
      r = $urandom;
      if ($urandom_range(0, 99) < 8) begin
        send_beat(make_write(r[IndexWidth-1:0], rand_sample(), rand_sample()), 1'b0, '0);
      end else begin
        sel = $urandom_range(0, 9);
        if (sel == 0 || n < 2) begin
          q = rand_sample();
        end else if (sel == 1) begin
          case (r[1:0])
            2'd0: q = 16'sh8000;
            2'd1: q = 16'sh7fff;
            2'd2: q = 16'sh0000;
            default: q = bp_input[$urandom_range(0, n - 1)];
          endcase
        end else begin
          seg  = $urandom_range(0, n - 2);
          lo_v = bp_input[seg];
          hi_v = bp_input[seg + 1];
          q = (lo_v <= hi_v) ? sample_t'(lo_v + $urandom_range(0, hi_v - lo_v)) : rand_sample();
        end
        send_beat(make_query(q), 1'b0, '0);
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= rx_hold || ($urandom_range(0, 99) < rx_stall_pct);
  end

  initial begin
    rx_hold = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, got value=%0d status=%0d sat=%0d",
                 $time, result_value_o, status_o, saturated_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (result_value_o !== want.value) begin
          $display("%0t: result_value mismatch: expected %0d, got %0d",
                   $time, want.value, result_value_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, status_o);
          mismatches++;
        end
        if (saturated_o !== want.sat) begin
          $display("%0t: saturated mismatch: expected %0d, got %0d",
                   $time, want.sat, saturated_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StuckLimit) begin
      $display("%0t: no beat moved for %0d cycles", $time, StuckLimit);
      $display("** piecewise_linear_interpolator: FAILED **");
      $finish;
    end
  end

  initial begin
    int p;
    int phase_counts [12];
    row_t rw;
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_point_count_i = '0;
    in_valid_i        = 1'b0;
    operation_i       = OP_WRITE;
    point_index_i     = '0;
    point_input_i     = '0;
    point_output_i    = '0;
    query_value_i     = '0;
    bp_count          = '0;
    for (p = 0; p < Depth; p++) begin
      bp_input[p]  = '0;
      bp_output[p] = '0;
    end
    phase_counts = '{16, 2, 31, 7, 17, 0, 16, 1, 12, 3, 16, 24};

    dir_beat(OP_QUERY, 0, 0, 0, 0, 1'b1, 0, STATUS_TOO_FEW, 1'b0);
    dir_beat(OP_QUERY, 0, 0, 0, -32768, 1'b1, 0, STATUS_TOO_FEW, 1'b0);
    dir_count(1);
    dir_beat(OP_QUERY, 15, 0, 0, 32767, 1'b1, 0, STATUS_TOO_FEW, 1'b0);
    dir_beat(OP_WRITE, 0, -256, 0, 0, 1'b0, 0, STATUS_OK, 1'b0);
    dir_beat(OP_WRITE, 1, 0, 256, 0, 1'b0, 0, STATUS_OK, 1'b0);
    dir_beat(OP_WRITE, 2, 512, -512, 0, 1'b0, 0, STATUS_OK, 1'b0);
    dir_beat(OP_WRITE, 3, 512, 1000, 0, 1'b0, 0, STATUS_OK, 1'b0);
    dir_count(4);
    dir_beat(OP_QUERY, 0, 0, 0, -256, 1'b1, 0, STATUS_OK, 1'b0);
    dir_beat(OP_QUERY, 0, 0, 0, -32768, 1'b0, 0, STATUS_OK, 1'b0);
    dir_beat(OP_QUERY, 0, 0, 0, 32767, 1'b1, 0, STATUS_ZERO_SPAN, 1'b0);
    dir_beat(OP_QUERY, 0, 0, 0, 256, 1'b0, 0, STATUS_OK, 1'b0);
    dir_beat(OP_QUERY, 0, 0, 0, 1, 1'b0, 0, STATUS_OK, 1'b0);
    dir_beat(OP_WRITE, 3, 513, 32767, 0, 1'b0, 0, STATUS_OK, 1'b0);
    dir_beat(OP_QUERY, 0, 0, 0, 32767, 1'b1, 32767, STATUS_OK, 1'b1);
    dir_beat(OP_QUERY, 0, 0, 0, 512, 1'b0, 0, STATUS_OK, 1'b0);
    dir_beat(OP_WRITE, 0, -1, -32768, 0, 1'b0, 0, STATUS_OK, 1'b0);
    dir_beat(OP_QUERY, 0, 0, 0, -32768, 1'b1, -32768, STATUS_OK, 1'b1);
    dir_beat(OP_WRITE, 1, -32768, 32767, 0, 1'b0, 0, STATUS_OK, 1'b0);
    dir_beat(OP_QUERY, 0, 0, 0, -100, 1'b0, 0, STATUS_OK, 1'b0);
    dir_beat(OP_QUERY, 0, 0, 0, 0, 1'b0, 0, STATUS_OK, 1'b0);
    dir_beat(OP_WRITE, 15, 32767, -32768, 0, 1'b0, 0, STATUS_OK, 1'b0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_idling(13, 76);

    foreach (directed_rows[p]) begin
      rw = directed_rows[p];
      if (rw.kind == ROW_COUNT) set_count(rw.count);
      else send_beat(rw.beat, rw.typed, rw.want);
    end

    for (p = 0; p < 12; p++) begin
      if (p == 4) set_idling(76, 13);
      if (p == 8) set_idling(0, 0);
      run_phase(phase_counts[p], PhaseItems, (p % 2) == 0, p == 5, p == 8);
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** piecewise_linear_interpolator: PASSED **");
    end else begin
      $display("** piecewise_linear_interpolator: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/pli_pkg.sv
design/pli_queue.sv
design/pli_front.sv
design/pli_engine.sv
design/piecewise_linear_interpolator.sv
tb/tb.sv
